@@ hw/rtl/hsc_pkg.sv @@
// hsc_pkg: shared types and constants of the hashed session cache.
// Holds the FNV-1a constants, field widths, request codes and state types.
// Depends on nothing.
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int KEY_IN_W = 256;
    localparam int LEN_W    = 6;
    localparam int HANDLE_W = 32;
    localparam int STAMP_W  = 64;
    localparam int COUNT_W  = 7;
    localparam int HASH_W   = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_BYTE,
        HS_QUOT,
        HS_BACK,
        HS_REM,
        HS_DONE
    } hash_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PRB_RD,
        ST_PRB_CHK,
        ST_SCN_RD,
        ST_SCN_CHK,
        ST_WRITE,
        ST_OUT
    } seq_state_t;

endpackage

@@ hw/rtl/hsc_hash.sv @@
// hsc_hash: serial FNV-1a hash, one key byte a cycle through one multiplier,
// then the hash modulo the bucket count by reciprocal multiplication on it.
// Depends on hsc_pkg.
`timescale 1ns / 1ps

module hsc_hash #(
    parameter int BUCKETS       = 64,
    parameter int KEY_BYTES_MAX = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [8*KEY_BYTES_MAX-1:0]          key_in,
    input  logic [hsc_pkg::LEN_W-1:0]           len_in,
    output logic                                done,
    output logic [$clog2(BUCKETS)-1:0]          bucket
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int KEY_W = 8 * KEY_BYTES_MAX;
    localparam int HW    = hsc_pkg::HASH_W;
    // floor(2^32 / BUCKETS): the quotient estimate is low by at most one
    localparam logic [HW-1:0] RECIP = HW'((64'd1 << HW) / 64'(BUCKETS));
    localparam logic [HW-1:0] B_EXT = HW'(BUCKETS);

    hsc_pkg::hash_state_t state_reg, state_next;

    logic [5:0]                  cnt_reg;
    logic [KEY_W-1:0]            sh_reg;
    logic [HW-1:0]               h_reg;
    logic [HW-1:0]               q_reg;
    logic [HW-1:0]               qb_reg;
    logic [IDX_W-1:0]            r_reg;
    logic [HW-1:0]               mul_a;
    logic [HW-1:0]               mul_b;
    logic [2*HW-1:0]             mul_p;
    logic [HW-1:0]               diff;
    logic [HW-1:0]               diff_fix;
    logic                        last_byte;

    assign last_byte = ((cnt_reg + 6'd1) == len_in);
    assign mul_p     = (2*HW)'(mul_a) * (2*HW)'(mul_b);
    assign diff      = h_reg - qb_reg;
    assign diff_fix  = (diff >= B_EXT) ? diff - B_EXT : diff;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hsc_pkg::HS_IDLE: if (start) state_next = hsc_pkg::HS_BYTE;
            hsc_pkg::HS_BYTE: if (last_byte) state_next = hsc_pkg::HS_QUOT;
            hsc_pkg::HS_QUOT: state_next = hsc_pkg::HS_BACK;
            hsc_pkg::HS_BACK: state_next = hsc_pkg::HS_REM;
            hsc_pkg::HS_REM:  state_next = hsc_pkg::HS_DONE;
            hsc_pkg::HS_DONE: state_next = hsc_pkg::HS_IDLE;
            default:          state_next = hsc_pkg::HS_IDLE;
        endcase
    end

    // operand select of the shared multiplier
    always_comb begin
        done   = (state_reg == hsc_pkg::HS_DONE);
        bucket = r_reg;
        mul_a  = h_reg ^ {24'd0, sh_reg[7:0]};
        mul_b  = hsc_pkg::FNV_PRIME;
        case (state_reg)
            hsc_pkg::HS_QUOT: begin
                mul_a = h_reg;
                mul_b = RECIP;
            end
            hsc_pkg::HS_BACK: begin
                mul_a = q_reg;
                mul_b = B_EXT;
            end
            default: begin
                mul_b = hsc_pkg::FNV_PRIME;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsc_pkg::HS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            hsc_pkg::HS_IDLE: begin
                cnt_reg <= '0;
                sh_reg  <= key_in;
                h_reg   <= hsc_pkg::FNV_BASIS;
            end
            hsc_pkg::HS_BYTE: begin
                h_reg   <= mul_p[HW-1:0];
                sh_reg  <= sh_reg >> 8;
                cnt_reg <= last_byte ? 6'd0 : cnt_reg + 6'd1;
            end
            hsc_pkg::HS_QUOT: begin
                q_reg <= mul_p[2*HW-1:HW];
            end
            hsc_pkg::HS_BACK: begin
                // quotient times bucket count never exceeds the hash
                qb_reg <= mul_p[HW-1:0];
            end
            hsc_pkg::HS_REM: begin
                r_reg <= diff_fix[IDX_W-1:0];
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

@@ hw/rtl/hashed_session_cache_lru_unit.sv @@
// hashed_session_cache_lru_unit: top level of the hashed session cache.
// Holds the request sequencer, the slot memories and the result register;
// depends on hsc_pkg and hsc_hash.
`timescale 1ns / 1ps

// A bounded key-to-handle map taking one lookup or insert request at a time.
// The key (1 to KEY_BYTES_MAX bytes) is hashed with FNV-1a one byte a cycle
// through a single 32-bit multiplier, then reduced modulo BUCKETS on the same
// multiplier: a reciprocal multiplication, a back multiplication and one
// correcting subtraction. The home slot and its successors are then probed
// one slot at a time (memory read, then compare). An insert that finds every
// slot full sweeps all use stamps, again one slot at a time, to find the
// least recently used slot. A lookup that misses skips the slot write.
// Rejected requests (bad length, or insert with handle 0) present their
// result on the cycle after acceptance. After reset the block clears the
// occupancy marks before it raises s_tready. A result is held on the master
// side until taken, and no new request is taken until then.
module hashed_session_cache_lru_unit #(
    parameter int BUCKETS       = 64,
    parameter int KEY_BYTES_MAX = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // key_word0, key_word1, key_word2, key_word3, key_length, handle_in, pad
    input  logic [295:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, handle_out, released_valid, released_handle, entry_count, pad
    output logic [79:0]  m_tdata,
    // status
    output logic [0:0]   m_tuser
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int KEY_W = 8 * KEY_BYTES_MAX;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);
    localparam logic [hsc_pkg::LEN_W-1:0] LEN_MAX = hsc_pkg::LEN_W'(KEY_BYTES_MAX);

    hsc_pkg::seq_state_t state_reg, state_next;

    // request fields as received
    logic [KEY_W-1:0]               key_raw;
    logic [hsc_pkg::LEN_W-1:0]      len_in;
    logic [hsc_pkg::HANDLE_W-1:0]   handle_in;
    logic                           req_in;
    logic                           bad_req;
    logic [KEY_W-1:0]               key_masked;

    // held request
    logic [KEY_W-1:0]               key_reg;
    logic [hsc_pkg::LEN_W-1:0]      len_reg;
    logic [hsc_pkg::HANDLE_W-1:0]   handle_reg;
    logic                           req_reg;

    // sequencer registers
    logic [IDX_W-1:0]               clr_idx_reg;
    logic [IDX_W-1:0]               slot_reg;
    logic [IDX_W-1:0]               step_reg;
    logic [IDX_W-1:0]               target_reg;
    logic [hsc_pkg::STAMP_W-1:0]    min_stamp_reg;
    logic [IDX_W-1:0]               min_idx_reg;
    logic [hsc_pkg::HANDLE_W-1:0]   min_handle_reg;
    logic                           wr_full_reg;
    logic                           fill_reg;
    logic [hsc_pkg::STAMP_W-1:0]    clock_reg;
    logic [hsc_pkg::COUNT_W-1:0]    count_reg;

    // result register
    logic                           status_reg;
    logic                           hit_reg;
    logic [hsc_pkg::HANDLE_W-1:0]   hout_reg;
    logic                           rel_v_reg;
    logic [hsc_pkg::HANDLE_W-1:0]   rel_h_reg;

    // slot memories
    logic [KEY_W-1:0]               key_mem    [BUCKETS];
    logic [hsc_pkg::LEN_W-1:0]      len_mem    [BUCKETS];
    logic [hsc_pkg::HANDLE_W-1:0]   handle_mem [BUCKETS];
    logic [hsc_pkg::STAMP_W-1:0]    stamp_mem  [BUCKETS];
    logic                           occ_mem    [BUCKETS];

    logic [KEY_W-1:0]               key_rd;
    logic [hsc_pkg::LEN_W-1:0]      len_rd;
    logic [hsc_pkg::HANDLE_W-1:0]   handle_rd;
    logic [hsc_pkg::STAMP_W-1:0]    stamp_rd;
    logic                           occ_rd;

    // control decoded from state
    logic [IDX_W-1:0]               rd_addr;
    logic                           occ_we;
    logic [IDX_W-1:0]               occ_waddr;
    logic                           occ_wdata;
    logic                           full_we;
    logic                           stamp_we;
    logic                           accept;
    logic                           hash_start;
    logic                           hash_done;
    logic [IDX_W-1:0]               hash_bucket;
    logic                           key_match;
    logic                           scan_take;

    assign key_raw   = s_tdata[KEY_W-1:0];
    assign len_in    = s_tdata[261:256];
    assign handle_in = s_tdata[293:262];
    assign req_in    = s_tuser[0];
    assign bad_req   = (len_in == '0) || (len_in > LEN_MAX)
                     || ((req_in == hsc_pkg::REQ_INSERT) && (handle_in == '0));
    assign accept    = s_tvalid && s_tready;

    // drop key bytes beyond the length so stored keys compare whole
    for (genvar j = 0; j < KEY_BYTES_MAX; j++) begin : g_mask
        assign key_masked[8*j +: 8] =
            (hsc_pkg::LEN_W'(j) < len_in) ? key_raw[8*j +: 8] : 8'd0;
    end

    assign key_match = (len_rd == len_reg) && (key_rd == key_reg);
    assign scan_take = (slot_reg == '0) || (stamp_rd < min_stamp_reg);

    hsc_hash #(
        .BUCKETS       (BUCKETS),
        .KEY_BYTES_MAX (KEY_BYTES_MAX)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key_in  (key_reg),
        .len_in  (len_reg),
        .done    (hash_done),
        .bucket  (hash_bucket)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hsc_pkg::ST_CLEAR: begin
                if (clr_idx_reg == LAST) state_next = hsc_pkg::ST_IDLE;
            end
            hsc_pkg::ST_IDLE: begin
                if (accept) state_next = bad_req ? hsc_pkg::ST_OUT : hsc_pkg::ST_HASH;
            end
            hsc_pkg::ST_HASH: begin
                if (hash_done) state_next = hsc_pkg::ST_PRB_RD;
            end
            hsc_pkg::ST_PRB_RD: state_next = hsc_pkg::ST_PRB_CHK;
            hsc_pkg::ST_PRB_CHK: begin
                if (!occ_rd) begin
                    state_next = (req_reg == hsc_pkg::REQ_INSERT)
                               ? hsc_pkg::ST_WRITE : hsc_pkg::ST_OUT;
                end else if (key_match) begin
                    state_next = hsc_pkg::ST_WRITE;
                end else if (step_reg == LAST) begin
                    state_next = (req_reg == hsc_pkg::REQ_INSERT)
                               ? hsc_pkg::ST_SCN_RD : hsc_pkg::ST_OUT;
                end else begin
                    state_next = hsc_pkg::ST_PRB_RD;
                end
            end
            hsc_pkg::ST_SCN_RD: state_next = hsc_pkg::ST_SCN_CHK;
            hsc_pkg::ST_SCN_CHK: begin
                state_next = (slot_reg == LAST) ? hsc_pkg::ST_WRITE : hsc_pkg::ST_SCN_RD;
            end
            hsc_pkg::ST_WRITE: state_next = hsc_pkg::ST_OUT;
            hsc_pkg::ST_OUT: begin
                if (m_tready) state_next = hsc_pkg::ST_IDLE;
            end
            default: state_next = hsc_pkg::ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        s_tready   = (state_reg == hsc_pkg::ST_IDLE);
        m_tvalid   = (state_reg == hsc_pkg::ST_OUT);
        hash_start = (state_reg == hsc_pkg::ST_HASH);
        rd_addr    = slot_reg;
        occ_we     = 1'b0;
        occ_waddr  = target_reg;
        occ_wdata  = 1'b1;
        full_we    = 1'b0;
        stamp_we   = 1'b0;
        case (state_reg)
            hsc_pkg::ST_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = clr_idx_reg;
                occ_wdata = 1'b0;
            end
            hsc_pkg::ST_WRITE: begin
                occ_we   = wr_full_reg;
                full_we  = wr_full_reg;
                stamp_we = 1'b1;
            end
            default: begin
                occ_we = 1'b0;
            end
        endcase
        m_tuser = status_reg;
        m_tdata = {7'd0, count_reg, rel_h_reg, rel_v_reg, hout_reg, hit_reg};
    end

    // slot memories: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
        if (full_we) begin
            key_mem[target_reg]    <= key_reg;
            len_mem[target_reg]    <= len_reg;
            handle_mem[target_reg] <= handle_reg;
        end
        if (stamp_we) stamp_mem[target_reg] <= clock_reg;
        occ_rd    <= occ_mem[rd_addr];
        key_rd    <= key_mem[rd_addr];
        len_rd    <= len_mem[rd_addr];
        handle_rd <= handle_mem[rd_addr];
        stamp_rd  <= stamp_mem[rd_addr];
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hsc_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            clock_reg   <= '0;
            count_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hsc_pkg::ST_CLEAR) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (accept && !bad_req) clock_reg <= clock_reg + 1'b1;
            if ((state_reg == hsc_pkg::ST_WRITE) && fill_reg) count_reg <= count_reg + 1'b1;
        end

        case (state_reg)
            hsc_pkg::ST_IDLE: begin
                key_reg    <= key_masked;
                len_reg    <= len_in;
                handle_reg <= handle_in;
                req_reg    <= req_in;
                status_reg <= bad_req ? hsc_pkg::STATUS_BAD : hsc_pkg::STATUS_OK;
                hit_reg    <= 1'b0;
                hout_reg   <= '0;
                rel_v_reg  <= 1'b0;
                rel_h_reg  <= '0;
                fill_reg   <= 1'b0;
            end
            hsc_pkg::ST_HASH: begin
                slot_reg <= hash_bucket;
                step_reg <= '0;
            end
            hsc_pkg::ST_PRB_CHK: begin
                target_reg  <= slot_reg;
                wr_full_reg <= (req_reg == hsc_pkg::REQ_INSERT);
                if (!occ_rd) begin
                    fill_reg <= 1'b1;
                end else if (key_match) begin
                    if (req_reg == hsc_pkg::REQ_INSERT) begin
                        rel_v_reg <= 1'b1;
                        rel_h_reg <= handle_rd;
                    end else begin
                        hit_reg  <= 1'b1;
                        hout_reg <= handle_rd;
                    end
                end else if (step_reg == LAST) begin
                    // every slot probed: sweep stamps from slot zero
                    slot_reg <= '0;
                end else begin
                    slot_reg <= (slot_reg == LAST) ? '0 : slot_reg + 1'b1;
                    step_reg <= step_reg + 1'b1;
                end
            end
            hsc_pkg::ST_SCN_CHK: begin
                if (scan_take) begin
                    min_stamp_reg  <= stamp_rd;
                    min_idx_reg    <= slot_reg;
                    min_handle_reg <= handle_rd;
                end
                if (slot_reg == LAST) begin
                    target_reg <= scan_take ? slot_reg : min_idx_reg;
                    rel_v_reg  <= 1'b1;
                    rel_h_reg  <= scan_take ? handle_rd : min_handle_reg;
                end else begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    // a lookup never releases, an insert never hits
    a_hit_xor_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(hit_reg && rel_v_reg))
        else $error("hit and release reported together");

    // rejected requests carry no hit and no release
    a_bad_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status_reg == hsc_pkg::STATUS_BAD)) |-> (!hit_reg && !rel_v_reg))
        else $error("rejected request reported an action");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while busy");

    // count changes only in the slot write state; it rises there only when an insert fills an empty slot
    a_count_on_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != hsc_pkg::ST_WRITE) |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside a slot write");

endmodule
